// File: rtl/hmvn_pkg.sv
`timescale 1ns / 1ps

package hmvn_pkg;

    localparam logic [1:0] CFG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;

    localparam logic [10:0] GRID_WIDTH_RESET   = 11'd1024;
    localparam logic [12:0] GRID_HEIGHT_RESET  = 13'd1024;
    localparam logic [15:0] HEIGHT_SCALE_RESET = 16'd256;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 17;

    localparam logic [15:0] Q15_ONE = 16'd32767;

    typedef struct packed {
        logic signed [10:0] dx;
        logic signed [10:0] dz;
        logic [2:0]         count;
        logic [9:0]         column;
        logic [11:0]        row;
        logic               last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: rtl/hmvn_front.sv
`timescale 1ns / 1ps

module hmvn_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [$clog2(MAX_WIDTH)-1:0]  w_last,
    input  logic [$clog2(MAX_HEIGHT)-1:0] h_last,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    height,
    output logic                          push,
    output hmvn_pkg::job_t                push_job,
    input  hmvn_pkg::fifo_stat_t          stat
);
    import hmvn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef enum logic [3:0] {
        F_IDLE, F_RD0, F_RD1, F_RD2, F_RD3, F_JOB1, F_JOB2, F_WR0, F_WR1
    } fstate_t;

    fstate_t         state_reg;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;
    logic [7:0]      left_reg;
    logic [7:0]      cur_reg;
    logic [7:0]      old_win_reg [3];
    logic [7:0]      prev_win_reg [3];
    logic            rd_zero_q_reg;
    logic [7:0]      old_q_reg;
    logic [7:0]      prev_q_reg;

    logic [7:0]      older_mem [MAX_WIDTH];
    logic [7:0]      prev_mem [MAX_WIDTH];

    logic                 row_end;
    logic                 last_row;
    logic                 right_ok;
    logic signed [CW+1:0] rd_idx;
    logic signed [CW+1:0] rd_k;
    logic                 rd_zero;
    logic [CW-1:0]        rd_addr;
    logic                 wr_en;
    logic [CW-1:0]        wr_addr;
    logic [7:0]           wr_old;
    logic [7:0]           wr_prev;
    logic [7:0]           left_or0;
    logic [RW-1:0]        row_one;
    logic [31:0]          col32;
    logic [31:0]          row32;

    assign row_end  = col_reg >= w_last;
    assign right_ok = col_reg < w_last;
    assign last_row = row_reg >= h_last;
    assign left_or0 = (col_reg != '0) ? left_reg : 8'd0;
    assign row_one  = RW'(1);
    assign s_tready = (state_reg == F_IDLE);
    assign push     = (state_reg == F_JOB1 || state_reg == F_JOB2) && !stat.full;

    always_comb begin
        case (state_reg)
            F_RD1:   rd_k = (CW+2)'(1);
            F_RD2:   rd_k = (CW+2)'(2);
            default: rd_k = '0;
        endcase
        rd_idx  = $signed({2'b00, col_reg}) - (CW+2)'(1) + rd_k;
        rd_zero = (rd_idx < 0) || (rd_idx >= (CW+2)'(MAX_WIDTH));
        rd_addr = rd_zero ? '0 : rd_idx[CW-1:0];
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = col_reg - CW'(1);
        wr_old  = prev_win_reg[0];
        wr_prev = left_reg;
        case (state_reg)
            F_WR0: begin
                wr_en = (col_reg != '0);
            end
            F_WR1: begin
                wr_en   = row_end;
                wr_addr = col_reg;
                wr_old  = prev_win_reg[1];
                wr_prev = cur_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        old_q_reg  <= older_mem[rd_addr];
        prev_q_reg <= prev_mem[rd_addr];
        if (wr_en) begin
            older_mem[wr_addr] <= wr_old;
            prev_mem[wr_addr]  <= wr_prev;
        end
    end

    // face sums for the vertex in flight
    always_comb begin
        logic signed [8:0]  win [3][3];
        logic signed [10:0] dx;
        logic signed [10:0] dz;
        logic [2:0]         cnt;
        logic               second;
        logic               below;
        logic               above;
        logic               vy;
        logic               vx;
        second = (state_reg == F_JOB2);
        for (int k = 0; k < 3; k++) begin
            win[0][k] = second ? $signed({1'b0, prev_win_reg[k]})
                               : $signed({1'b0, old_win_reg[k]});
            win[1][k] = second ? 9'sd0 : $signed({1'b0, prev_win_reg[k]});
            win[2][k] = 9'sd0;
        end
        if (second) begin
            win[1][0] = $signed({1'b0, left_or0});
            win[1][1] = $signed({1'b0, cur_reg});
        end else begin
            win[2][0] = $signed({1'b0, left_or0});
            win[2][1] = $signed({1'b0, cur_reg});
        end
        below = second ? 1'b1 : (row_reg >= RW'(2));
        above = !second;
        dx  = '0;
        dz  = '0;
        cnt = '0;
        for (int y = 0; y < 2; y++) begin
            for (int x = 0; x < 2; x++) begin
                vy = (y == 0) ? below : above;
                vx = (x == 0) ? (col_reg != '0) : right_ok;
                if (vy && vx) begin
                    dx  = dx + 11'(win[y][x]) - 11'(win[y][x+1]);
                    dz  = dz + 11'(win[y][x]) - 11'(win[y+1][x]);
                    cnt = cnt + 3'd1;
                end
            end
        end
        col32 = 32'(col_reg);
        row32 = second ? 32'(row_reg) : 32'(row_reg - row_one);
        push_job.dx     = dx;
        push_job.dz     = dz;
        push_job.count  = cnt;
        push_job.column = col32[9:0];
        push_job.row    = row32[11:0];
        push_job.last   = second && row_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
        end else begin
            rd_zero_q_reg <= rd_zero;
            case (state_reg)
                F_IDLE: begin
                    if (s_tvalid) begin
                        cur_reg   <= height;
                        state_reg <= F_RD0;
                    end
                end
                F_RD0: state_reg <= F_RD1;
                F_RD1: begin
                    old_win_reg[0]  <= rd_zero_q_reg ? 8'd0 : old_q_reg;
                    prev_win_reg[0] <= rd_zero_q_reg ? 8'd0 : prev_q_reg;
                    state_reg       <= F_RD2;
                end
                F_RD2: begin
                    old_win_reg[1]  <= rd_zero_q_reg ? 8'd0 : old_q_reg;
                    prev_win_reg[1] <= rd_zero_q_reg ? 8'd0 : prev_q_reg;
                    state_reg       <= F_RD3;
                end
                F_RD3: begin
                    old_win_reg[2]  <= rd_zero_q_reg ? 8'd0 : old_q_reg;
                    prev_win_reg[2] <= rd_zero_q_reg ? 8'd0 : prev_q_reg;
                    state_reg       <= (row_reg != '0) ? F_JOB1 : F_WR0;
                end
                F_JOB1: begin
                    if (!stat.full) begin
                        state_reg <= last_row ? F_JOB2 : F_WR0;
                    end
                end
                F_JOB2: begin
                    if (!stat.full) begin
                        state_reg <= F_WR0;
                    end
                end
                F_WR0: state_reg <= F_WR1;
                F_WR1: begin
                    left_reg <= cur_reg;
                    if (row_end) begin
                        col_reg <= '0;
                        row_reg <= last_row ? '0 : row_reg + row_one;
                    end else begin
                        col_reg <= col_reg + CW'(1);
                    end
                    state_reg <= F_IDLE;
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/hmvn_fifo.sv
`timescale 1ns / 1ps

module hmvn_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  hmvn_pkg::job_t       push_job,
    input  logic                 pop,
    output hmvn_pkg::job_t       pop_job,
    output hmvn_pkg::fifo_stat_t stat
);
    import hmvn_pkg::*;

    job_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   fill_reg;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (fill_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (fill_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   fill_reg <= fill_reg + (FIFO_AW+1)'(1);
                2'b01:   fill_reg <= fill_reg - (FIFO_AW+1)'(1);
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule

// File: rtl/hmvn_back.sv
`timescale 1ns / 1ps

module hmvn_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [15:0]          scale,
    input  hmvn_pkg::fifo_stat_t stat,
    output logic                 pop,
    input  hmvn_pkg::job_t       pop_job,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [71:0]          m_tdata,
    output logic                 m_tlast
);
    import hmvn_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_MAG, B_SQ, B_SUM, B_DINIT, B_DIV, B_SINIT, B_SQRT, B_COMP, B_FIN
    } bstate_t;

    bstate_t     state_reg;
    job_t        job_reg;
    logic [17:0] mag_reg [3];
    logic        neg_reg [3];
    logic [35:0] sq_reg [3];
    logic [37:0] s_reg;
    logic [1:0]  comp_reg;
    logic [5:0]  step_reg;
    logic [38:0] rem_reg;
    logic [32:0] quo_reg;
    logic [33:0] src_reg;
    logic [16:0] root_reg;
    logic [18:0] srem_reg;
    logic [15:0] val_reg [3];
    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic [10:0] adx;
    logic [10:0] adz;
    logic [17:0] bprod;
    logic [38:0] div_t;
    logic        div_ge;
    logic [20:0] sq_t;
    logic [20:0] sq_trial;
    logic        sq_ge;
    logic [17:0] r_inc;
    logic [16:0] r_half;
    logic [15:0] r_cap;
    logic        out_free;

    assign pop      = (state_reg == B_IDLE) && !stat.empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign adx   = job_reg.dx[10] ? 11'(-job_reg.dx) : 11'(job_reg.dx);
    assign adz   = job_reg.dz[10] ? 11'(-job_reg.dz) : 11'(job_reg.dz);
    assign bprod = 18'(job_reg.count) * 18'(scale);

    assign div_t  = (step_reg == '0) ? rem_reg : {rem_reg[37:0], 1'b0};
    assign div_ge = div_t >= {1'b0, s_reg};

    assign sq_t     = {srem_reg, src_reg[33:32]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    assign r_inc  = {1'b0, root_reg} + 18'd1;
    assign r_half = r_inc[17:1];
    assign r_cap  = (r_half > 17'(Q15_ONE)) ? Q15_ONE : r_half[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != B_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (!stat.empty) begin
                        job_reg   <= pop_job;
                        state_reg <= B_MAG;
                    end
                end
                B_MAG: begin
                    mag_reg[0] <= {adx[9:0], 8'd0};
                    mag_reg[1] <= bprod;
                    mag_reg[2] <= {adz[9:0], 8'd0};
                    neg_reg[0] <= job_reg.dx[10];
                    neg_reg[1] <= 1'b0;
                    neg_reg[2] <= job_reg.dz[10];
                    comp_reg   <= '0;
                    state_reg  <= B_SQ;
                end
                B_SQ: begin
                    sq_reg[comp_reg] <= mag_reg[comp_reg] * mag_reg[comp_reg];
                    if (comp_reg == 2'd2) begin
                        state_reg <= B_SUM;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                B_SUM: begin
                    s_reg     <= 38'(sq_reg[0]) + 38'(sq_reg[1]) + 38'(sq_reg[2]);
                    comp_reg  <= '0;
                    state_reg <= B_DINIT;
                end
                B_DINIT: begin
                    rem_reg   <= 39'(sq_reg[comp_reg]);
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= B_DIV;
                end
                // quotient of square times 2^32 over the sum, one bit a cycle
                B_DIV: begin
                    rem_reg <= div_ge ? div_t - {1'b0, s_reg} : div_t;
                    quo_reg <= {quo_reg[31:0], div_ge};
                    if (step_reg == 6'(DIV_STEPS - 1)) begin
                        state_reg <= B_SINIT;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                B_SINIT: begin
                    src_reg   <= {1'b0, quo_reg};
                    root_reg  <= '0;
                    srem_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= B_SQRT;
                end
                // integer square root, one result bit a cycle
                B_SQRT: begin
                    srem_reg <= sq_ge ? 19'(sq_t - sq_trial) : 19'(sq_t);
                    root_reg <= {root_reg[15:0], sq_ge};
                    src_reg  <= {src_reg[31:0], 2'b00};
                    if (step_reg == 6'(SQRT_STEPS - 1)) begin
                        state_reg <= B_COMP;
                    end else begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                B_COMP: begin
                    val_reg[comp_reg] <= neg_reg[comp_reg] ? 16'd0 - r_cap : r_cap;
                    if (comp_reg == 2'd2) begin
                        state_reg <= B_FIN;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= B_DINIT;
                    end
                end
                B_FIN: begin
                    if (out_free) begin
                        if (s_reg == '0) begin
                            m_tdata_reg <= {2'b00, job_reg.row, job_reg.column,
                                            16'd0, Q15_ONE, 16'd0};
                        end else begin
                            m_tdata_reg <= {2'b00, job_reg.row, job_reg.column,
                                            val_reg[2], val_reg[1], val_reg[0]};
                        end
                        m_tlast_reg  <= job_reg.last;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/height_map_vertex_normals_core.sv
`timescale 1ns / 1ps
// channel   dir  payload                                        handshake
// s_        in   tdata: height                                  tvalid/tready
// m_        out  tdata: normal_x, normal_y, normal_z, column,   tvalid/tready
//                row; tlast: frame_end
// cfg_      in   index, data (grid_width, grid_height, scale)   wr_en
//
// front: read states RD0-RD3, a job state per vertex queued, then WR0-WR1.
// back: per vertex, the shared divide and square-root unit runs once per
// component; last-row samples give two vertices.
// reset clears counters, queue and valid flags; line stores need no clearing.
// a four-entry queue lets the front run ahead while the back or m_ stalls.

module height_map_vertex_normals_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // height
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // normal_x, normal_y, normal_z, column, row, zero pad
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wr_data
);
    import hmvn_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [10:0] grid_width_reg;
    logic [12:0] grid_height_reg;
    logic [15:0] height_scale_reg;

    logic [31:0]   gw32;
    logic [31:0]   gh32;
    logic [31:0]   wl32;
    logic [31:0]   hl32;
    logic [CW-1:0] w_last;
    logic [RW-1:0] h_last;
    logic [15:0]   scale;

    logic       push;
    job_t       push_job;
    logic       pop;
    job_t       pop_job;
    fifo_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg   <= GRID_WIDTH_RESET;
            grid_height_reg  <= GRID_HEIGHT_RESET;
            height_scale_reg <= HEIGHT_SCALE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GRID_WIDTH:   grid_width_reg   <= cfg_wr_data[10:0];
                CFG_GRID_HEIGHT:  grid_height_reg  <= cfg_wr_data[12:0];
                CFG_HEIGHT_SCALE: height_scale_reg <= cfg_wr_data;
                default:          grid_width_reg   <= grid_width_reg;
            endcase
        end
    end

    always_comb begin
        gw32 = 32'(grid_width_reg);
        gh32 = 32'(grid_height_reg);
        wl32 = (gw32 < 32'd2) ? 32'd1 :
               (gw32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH - 1) : gw32 - 32'd1;
        hl32 = (gh32 < 32'd2) ? 32'd1 :
               (gh32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT - 1) : gh32 - 32'd1;
        w_last = wl32[CW-1:0];
        h_last = hl32[RW-1:0];
        scale  = (height_scale_reg == '0) ? 16'd1 : height_scale_reg;
    end

    hmvn_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .w_last  (w_last),
        .h_last  (h_last),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .height  (s_tdata),
        .push    (push),
        .push_job(push_job),
        .stat    (stat)
    );

    hmvn_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .pop_job (pop_job),
        .stat    (stat)
    );

    hmvn_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .scale   (scale),
        .stat    (stat),
        .pop     (pop),
        .pop_job (pop_job),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !stat.full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !stat.empty)
        else $error("pop from empty queue");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[71:70] == 2'b00))
        else $error("nonzero pad bits on result");

endmodule
